// ===== hw/rtl/bis_pkg.sv =====
// Shared types, widths and register codes of the bilinear image scaler.
package bis_pkg;

  // Default values of the top-level parameters.
  localparam int DEF_MAX_SRC_WIDTH    = 256;
  localparam int DEF_MAX_SRC_HEIGHT   = 256;
  localparam int DEF_MAX_CHANNELS     = 3;
  localparam int DEF_WEIGHT_FRAC_BITS = 8;

  // Fixed field widths.
  localparam int SRC_W      = 9;
  localparam int DST_W      = 12;
  localparam int CNT_W      = 2;
  localparam int PIX_W      = 8;
  localparam int CHAN_N     = 3;
  localparam int COORD_W    = 9;
  localparam int DEN_W      = DST_W + 1;
  localparam int NUM_W      = DST_W + 1 + SRC_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // Item kinds.
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_ASK  = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH     = 3'd0,
    CFG_SRC_HEIGHT    = 3'd1,
    CFG_DST_WIDTH     = 3'd2,
    CFG_DST_HEIGHT    = 3'd3,
    CFG_CHANNEL_COUNT = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic             kind;
    logic [7:0]       load_x;
    logic [7:0]       load_y;
    logic [PIX_W-1:0] in_chan0;
    logic [PIX_W-1:0] in_chan1;
    logic [PIX_W-1:0] in_chan2;
    logic [DST_W-1:0] dst_x;
    logic [DST_W-1:0] dst_y;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_chan0;
    logic [PIX_W-1:0] out_chan1;
    logic [PIX_W-1:0] out_chan2;
  } out_item_t;

endpackage

// ===== hw/rtl/bis_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with side data.
module bis_div #(
  parameter int N_W = 22,
  parameter int D_W = 13,
  parameter int Q_W = 22,
  parameter int S_W = 1
) (
  input  logic           clk,
  input  logic [N_W-1:0] num_i,
  input  logic [D_W-1:0] den_i,
  input  logic [S_W-1:0] side_i,
  output logic [Q_W-1:0] quo_o,
  output logic [D_W-1:0] rem_o,
  output logic [D_W-1:0] den_o,
  output logic [S_W-1:0] side_o
);

  logic [N_W+D_W-1:0] num_ext;
  logic [D_W-1:0]     r_r [Q_W];
  logic [Q_W-1:0]     n_r [Q_W];
  logic [Q_W-1:0]     q_r [Q_W];
  logic [D_W-1:0]     d_r [Q_W];
  logic [S_W-1:0]     s_r [Q_W];

  // The upper numerator bits start as the partial remainder.
  assign num_ext = {{D_W{1'b0}}, num_i};

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [D_W-1:0] r_in;
    logic [D_W-1:0] d_in;
    logic [Q_W-1:0] n_in;
    logic [Q_W-1:0] q_in;
    logic [S_W-1:0] s_in;
    logic [D_W:0]   trial;
    logic           ge;

    if (k == 0) begin : g_first
      assign r_in = num_ext[Q_W +: D_W];
      assign n_in = num_i[Q_W-1:0];
      assign q_in = '0;
      assign d_in = den_i;
      assign s_in = side_i;
    end else begin : g_next
      assign r_in = r_r[k-1];
      assign n_in = n_r[k-1];
      assign q_in = q_r[k-1];
      assign d_in = d_r[k-1];
      assign s_in = s_r[k-1];
    end

    // Shift in one numerator bit and subtract when it fits.
    assign trial = {r_in, n_in[Q_W-1]};
    assign ge    = (trial >= {1'b0, d_in});

    always_ff @(posedge clk) begin
      r_r[k] <= ge ? D_W'(trial - {1'b0, d_in}) : trial[D_W-1:0];
      n_r[k] <= n_in << 1;
      q_r[k] <= (q_in << 1) | Q_W'(ge);
      d_r[k] <= d_in;
      s_r[k] <= s_in;
    end
  end

  assign quo_o  = q_r[Q_W-1];
  assign rem_o  = r_r[Q_W-1];
  assign den_o  = d_r[Q_W-1];
  assign side_o = s_r[Q_W-1];

endmodule

// ===== hw/rtl/bis_axis.sv =====
// Maps one destination coordinate onto two source taps and a weight.
module bis_axis #(
  parameter int FRAC = bis_pkg::DEF_WEIGHT_FRAC_BITS
) (
  input  logic                        clk,
  input  logic [bis_pkg::DST_W-1:0]   d_i,
  input  logic [bis_pkg::SRC_W-1:0]   sn_i,
  input  logic [bis_pkg::DST_W-1:0]   dn_i,
  output logic [bis_pkg::COORD_W-1:0] i0_o,
  output logic [bis_pkg::COORD_W-1:0] i1_o,
  output logic [FRAC:0]               w_o
);

  localparam int NW  = bis_pkg::NUM_W;
  localparam int DW  = bis_pkg::DEN_W;
  localparam int CW  = bis_pkg::COORD_W;
  localparam int N2W = DW + FRAC + 2;

  logic [NW-1:0] prod;
  logic [NW-1:0] dn_ext;
  logic          neg_r;
  logic [NW-1:0] num_r;
  logic [DW-1:0] den_r;
  logic [DW-1:0] remneg_r;

  logic [NW-1:0] q1;
  logic [DW-1:0] r1;
  logic [DW-1:0] d1;
  logic [DW:0]   s1;
  logic [CW-1:0] smax;
  logic          q_big;
  logic [CW-1:0] x0_r;
  logic [CW-1:0] x1_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den2_r;

  logic [N2W-1:0]  num2;
  logic [DW:0]     d2_unused;
  logic [DW:0]     r2_unused;
  logic [2*CW-1:0] s2;

  // Numerator (2d+1)*sn - dn; a negative one always lies above -2dn.
  assign prod   = {{(NW-bis_pkg::DST_W-1){1'b0}}, d_i, 1'b1}
                * {{(NW-bis_pkg::SRC_W){1'b0}}, sn_i};
  assign dn_ext = NW'(dn_i);

  always_ff @(posedge clk) begin
    neg_r    <= (prod < dn_ext);
    num_r    <= prod - dn_ext;
    den_r    <= {dn_i, 1'b0};
    remneg_r <= DW'(prod + dn_ext);
  end

  bis_div #(.N_W(NW), .D_W(DW), .Q_W(NW), .S_W(DW + 1)) u_div_pos (
    .clk    (clk),
    .num_i  (neg_r ? '0 : num_r),
    .den_i  (den_r),
    .side_i ({neg_r, remneg_r}),
    .quo_o  (q1),
    .rem_o  (r1),
    .den_o  (d1),
    .side_o (s1)
  );

  // Floor quotient and clamping of both taps; a negative numerator gives -1.
  assign smax  = sn_i - CW'(1);
  assign q_big = (q1 >= NW'(smax));

  always_ff @(posedge clk) begin
    x0_r   <= s1[DW] ? '0 : (q_big ? smax : q1[CW-1:0]);
    x1_r   <= s1[DW] ? '0 : (q_big ? smax : q1[CW-1:0] + CW'(1));
    rem_r  <= s1[DW] ? s1[DW-1:0] : r1;
    den2_r <= d1;
  end

  // Rounded weight: (rem*2^(F+1) + den) div (2*den).
  assign num2 = N2W'({rem_r, {(FRAC+1){1'b0}}}) + N2W'(den2_r);

  bis_div #(.N_W(N2W), .D_W(DW + 1), .Q_W(FRAC + 1), .S_W(2 * CW)) u_div_wt (
    .clk    (clk),
    .num_i  (num2),
    .den_i  ({den2_r, 1'b0}),
    .side_i ({x0_r, x1_r}),
    .quo_o  (w_o),
    .rem_o  (r2_unused),
    .den_o  (d2_unused),
    .side_o (s2)
  );

  assign i0_o = s2[2*CW-1:CW];
  assign i1_o = s2[CW-1:0];

endmodule

// ===== hw/rtl/bis_lane.sv =====
// One channel lane: horizontal then vertical weighted mix over two stages.
module bis_lane #(
  parameter int FRAC = bis_pkg::DEF_WEIGHT_FRAC_BITS
) (
  input  logic                      clk,
  input  logic [bis_pkg::PIX_W-1:0] p00_i,
  input  logic [bis_pkg::PIX_W-1:0] p10_i,
  input  logic [bis_pkg::PIX_W-1:0] p01_i,
  input  logic [bis_pkg::PIX_W-1:0] p11_i,
  input  logic [FRAC:0]             wx_i,
  input  logic [FRAC:0]             wy_i,
  output logic [bis_pkg::PIX_W:0]   val_o
);

  localparam int VW  = bis_pkg::PIX_W + 1;
  localparam int P1W = FRAC + 1 + bis_pkg::PIX_W + 1;
  localparam int P2W = FRAC + 1 + VW + 1;
  localparam logic [FRAC:0] SCALE = {1'b1, {FRAC{1'b0}}};

  logic [FRAC:0]  wxi;
  logic [FRAC:0]  wyi;
  logic [P1W-1:0] sum_top;
  logic [P1W-1:0] sum_bot;
  logic [VW-1:0]  top_r;
  logic [VW-1:0]  bot_r;
  logic [FRAC:0]  wy_r;
  logic [P2W-1:0] sum_val;

  // Horizontal mix of the upper and lower row pairs.
  assign wxi     = SCALE - wx_i;
  assign sum_top = P1W'(wxi) * P1W'(p00_i) + P1W'(wx_i) * P1W'(p10_i);
  assign sum_bot = P1W'(wxi) * P1W'(p01_i) + P1W'(wx_i) * P1W'(p11_i);

  always_ff @(posedge clk) begin
    top_r <= sum_top[FRAC +: VW];
    bot_r <= sum_bot[FRAC +: VW];
    wy_r  <= wy_i;
  end

  // Vertical mix of the two row results.
  assign wyi     = SCALE - wy_r;
  assign sum_val = P2W'(wyi) * P2W'(top_r) + P2W'(wy_r) * P2W'(bot_r);

  always_ff @(posedge clk) begin
    val_o <= sum_val[FRAC +: VW];
  end

endmodule

// ===== hw/rtl/bilinear_image_scaler.sv =====
// Top level of the bilinear image scaler: frame store banks, lanes and merge.
//
// Items enter on in_data with start; an item is taken at any clock edge where
// start is high and busy is low. busy is high only during reset, so one item
// can be taken every cycle. Load items (kind 0) write one source pixel into the
// frame store and give no result. Ask items (kind 1) return one result on
// out_data, marked by a one-cycle out_valid strobe, in the order they came.
// The receiver cannot stall: results must be taken when out_valid is high.
// Each axis has two pipelined dividers: 22 stages for the tap index and
// WEIGHT_FRAC_BITS + 1 stages for the weight; they are followed by the store
// read and two mix stages. The store is split into four banks by column and
// row parity, so all four taps are read together. Loads go through the same
// pipeline and write at the read stage, keeping store order equal to item order.
// Configuration writes use cfg_valid/cfg_ready/cfg_index/cfg_data; the user
// must make them only while no item is in flight, which the block does not
// enforce. Reset restores the register defaults and empties the pipeline; the
// store contents stay undefined until loaded.
module bilinear_image_scaler #(
  parameter int MAX_SRC_WIDTH    = bis_pkg::DEF_MAX_SRC_WIDTH,
  parameter int MAX_SRC_HEIGHT   = bis_pkg::DEF_MAX_SRC_HEIGHT,
  parameter int MAX_CHANNELS     = bis_pkg::DEF_MAX_CHANNELS,
  parameter int WEIGHT_FRAC_BITS = bis_pkg::DEF_WEIGHT_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  bis_pkg::in_item_t              in_data,
  output logic                           out_valid,
  output bis_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bis_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bis_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int FRAC    = WEIGHT_FRAC_BITS;
  localparam int LANES   = (MAX_CHANNELS < 3) ? MAX_CHANNELS : 3;
  localparam int BANK_W  = (MAX_SRC_WIDTH + 1) / 2;
  localparam int BANK_H  = (MAX_SRC_HEIGHT + 1) / 2;
  localparam int BANK_D  = BANK_W * BANK_H;
  localparam int ADDR_W  = (BANK_D > 1) ? $clog2(BANK_D) : 1;
  localparam int DATA_W  = bis_pkg::PIX_W * LANES;
  localparam int AX_LAT  = bis_pkg::NUM_W + FRAC + 3;
  localparam int CW      = bis_pkg::COORD_W;
  localparam int PW      = bis_pkg::PIX_W;
  localparam int SW_CAP  = (MAX_SRC_WIDTH > 511) ? 511 : MAX_SRC_WIDTH;
  localparam int SH_CAP  = (MAX_SRC_HEIGHT > 511) ? 511 : MAX_SRC_HEIGHT;

  logic                        busy_r;
  logic [bis_pkg::SRC_W-1:0]   src_width_r;
  logic [bis_pkg::SRC_W-1:0]   src_height_r;
  logic [bis_pkg::DST_W-1:0]   dst_width_r;
  logic [bis_pkg::DST_W-1:0]   dst_height_r;
  logic [bis_pkg::CNT_W-1:0]   channel_count_r;
  logic [bis_pkg::SRC_W-1:0]   sw_eff;
  logic [bis_pkg::SRC_W-1:0]   sh_eff;
  logic [bis_pkg::DST_W-1:0]   dw_eff;
  logic [bis_pkg::DST_W-1:0]   dh_eff;
  logic [bis_pkg::CNT_W-1:0]   nch_eff;

  logic                        accept;
  logic                        v0_r;
  bis_pkg::in_item_t           item0_r;
  logic                        vdly_r [AX_LAT];
  bis_pkg::in_item_t           mdly_r [AX_LAT];

  logic [CW-1:0]               x0;
  logic [CW-1:0]               x1;
  logic [CW-1:0]               y0;
  logic [CW-1:0]               y1;
  logic [FRAC:0]               wx;
  logic [FRAC:0]               wy;

  logic                        m_v;
  bis_pkg::in_item_t           m_item;
  logic                        we;
  logic [1:0]                  wbank;
  logic [ADDR_W-1:0]           waddr;
  logic [DATA_W-1:0]           wdata;
  logic [DATA_W-1:0]           rd_r [4];
  logic                        ask_m_r;
  logic [1:0]                  b00_r;
  logic [1:0]                  b10_r;
  logic [1:0]                  b01_r;
  logic [1:0]                  b11_r;
  logic [FRAC:0]               wx_r;
  logic [FRAC:0]               wy_r;
  logic                        ask_l1_r;
  logic                        ask_l2_r;
  logic [PW:0]                 lane_val [bis_pkg::CHAN_N];
  logic [PW-1:0]               chan_res [bis_pkg::CHAN_N];
  logic                        out_valid_r;
  bis_pkg::out_item_t          out_data_r;

  // Ready after reset; the pipeline takes an item every cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy      = busy_r;
  assign cfg_ready = ~busy_r;
  assign accept    = start & ~busy_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r     <= 9'd256;
      src_height_r    <= 9'd256;
      dst_width_r     <= 12'd512;
      dst_height_r    <= 12'd512;
      channel_count_r <= 2'd3;
    end else if (cfg_valid && cfg_ready) begin
      unique case (bis_pkg::cfg_reg_t'(cfg_index))
        bis_pkg::CFG_SRC_WIDTH:     src_width_r     <= cfg_data[bis_pkg::SRC_W-1:0];
        bis_pkg::CFG_SRC_HEIGHT:    src_height_r    <= cfg_data[bis_pkg::SRC_W-1:0];
        bis_pkg::CFG_DST_WIDTH:     dst_width_r     <= cfg_data;
        bis_pkg::CFG_DST_HEIGHT:    dst_height_r    <= cfg_data;
        bis_pkg::CFG_CHANNEL_COUNT: channel_count_r <= cfg_data[bis_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Register values brought into their working ranges.
  always_comb begin
    sw_eff = src_width_r;
    if (src_width_r == '0) sw_eff = 9'd1;
    else if (src_width_r > 9'(SW_CAP)) sw_eff = 9'(SW_CAP);
    sh_eff = src_height_r;
    if (src_height_r == '0) sh_eff = 9'd1;
    else if (src_height_r > 9'(SH_CAP)) sh_eff = 9'(SH_CAP);
    dw_eff = (dst_width_r == '0) ? 12'd1 : dst_width_r;
    dh_eff = (dst_height_r == '0) ? 12'd1 : dst_height_r;
    nch_eff = channel_count_r;
    if (channel_count_r == '0) nch_eff = 2'd1;
    else if (channel_count_r > 2'(LANES)) nch_eff = 2'(LANES);
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item0_r <= in_data;
    end
  end

  // Column and row mapping run side by side.
  bis_axis #(.FRAC(FRAC)) u_axis_x (
    .clk  (clk),
    .d_i  (item0_r.dst_x),
    .sn_i (sw_eff),
    .dn_i (dw_eff),
    .i0_o (x0),
    .i1_o (x1),
    .w_o  (wx)
  );

  bis_axis #(.FRAC(FRAC)) u_axis_y (
    .clk  (clk),
    .d_i  (item0_r.dst_y),
    .sn_i (sh_eff),
    .dn_i (dh_eff),
    .i0_o (y0),
    .i1_o (y1),
    .w_o  (wy)
  );

  // Item kind and load data follow the mapping pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AX_LAT; i++) vdly_r[i] <= 1'b0;
    end else begin
      vdly_r[0] <= v0_r;
      for (int i = 1; i < AX_LAT; i++) vdly_r[i] <= vdly_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    mdly_r[0] <= item0_r;
    for (int i = 1; i < AX_LAT; i++) mdly_r[i] <= mdly_r[i-1];
  end

  assign m_v    = vdly_r[AX_LAT-1];
  assign m_item = mdly_r[AX_LAT-1];

  // Load write into the bank chosen by column and row parity.
  assign we    = m_v && (m_item.kind == bis_pkg::KIND_LOAD)
              && (32'(m_item.load_x) < 32'(MAX_SRC_WIDTH))
              && (32'(m_item.load_y) < 32'(MAX_SRC_HEIGHT));
  assign wbank = {m_item.load_y[0], m_item.load_x[0]};
  assign waddr = ADDR_W'(32'(m_item.load_y >> 1) * 32'(BANK_W) + 32'(m_item.load_x >> 1));
  assign wdata = DATA_W'({m_item.in_chan2, m_item.in_chan1, m_item.in_chan0});

  // Four banks; each reads the tap of its own parity.
  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [DATA_W-1:0] mem [BANK_D];
    logic [CW-1:0]     xs;
    logic [CW-1:0]     ys;
    logic [ADDR_W-1:0] raddr;

    assign xs    = (x0[0] == b[0]) ? x0 : x1;
    assign ys    = (y0[0] == b[1]) ? y0 : y1;
    assign raddr = ADDR_W'(32'(ys >> 1) * 32'(BANK_W) + 32'(xs >> 1));

    always_ff @(posedge clk) begin
      if (we && (wbank == 2'(b))) begin
        mem[waddr] <= wdata;
      end
      rd_r[b] <= mem[raddr];
    end
  end

  // Bank select and weights alongside the read data.
  always_ff @(posedge clk) begin
    b00_r <= {y0[0], x0[0]};
    b10_r <= {y0[0], x1[0]};
    b01_r <= {y1[0], x0[0]};
    b11_r <= {y1[0], x1[0]};
    wx_r  <= wx;
    wy_r  <= wy;
  end

  // Valid of an ask item through read and mix stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ask_m_r  <= 1'b0;
      ask_l1_r <= 1'b0;
      ask_l2_r <= 1'b0;
    end else begin
      ask_m_r  <= m_v && (m_item.kind == bis_pkg::KIND_ASK);
      ask_l1_r <= ask_m_r;
      ask_l2_r <= ask_l1_r;
    end
  end

  // Channel lanes.
  for (genvar c = 0; c < bis_pkg::CHAN_N; c++) begin : g_lane
    if (c < LANES) begin : g_used
      bis_lane #(.FRAC(FRAC)) u_lane (
        .clk   (clk),
        .p00_i (rd_r[b00_r][PW*c +: PW]),
        .p10_i (rd_r[b10_r][PW*c +: PW]),
        .p01_i (rd_r[b01_r][PW*c +: PW]),
        .p11_i (rd_r[b11_r][PW*c +: PW]),
        .wx_i  (wx_r),
        .wy_i  (wy_r),
        .val_o (lane_val[c])
      );
    end else begin : g_none
      assign lane_val[c] = '0;
    end

    // Merge: saturate, and zero channels not in use.
    assign chan_res[c] = (2'(c) >= nch_eff) ? '0
                       : (lane_val[c][PW] ? {PW{1'b1}} : lane_val[c][PW-1:0]);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ask_l2_r;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r.out_chan0 <= chan_res[0];
    out_data_r.out_chan1 <= chan_res[1];
    out_data_r.out_chan2 <= chan_res[2];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
